// ===== hw/rtl/bbtm_pkg.sv =====
// Shared types and constants for the block buffer tag manager.
// Used by bbtm_ctrl, bbtm_datapath and block_buffer_tag_manager; no dependencies.
package bbtm_pkg;

  localparam int SLOT_COUNT      = 32;
  localparam int MAX_DISK_BLOCKS = 8192;
  localparam int AGE_BITS        = 16;

  localparam int BLK_W      = 14;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 5;
  localparam int OUT_WB_W   = 13;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int TREE_N = 1 << SLOT_W;
  localparam int TREE_L1 = (SLOT_W + 1) / 2;
  localparam int TREE_L2 = SLOT_W - TREE_L1;
  localparam int CAND_N = TREE_N >> TREE_L1;
  localparam int TAG_W  = ($clog2(MAX_DISK_BLOCKS) < BLK_W) ? $clog2(MAX_DISK_BLOCKS) : BLK_W;

  localparam logic [BLK_W-1:0] DISK_COUNT_RESET = BLK_W'(8192);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_SET_DIRTY = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_OOB  = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE
  } fsm_e;

  typedef struct packed {
    logic capture;
    logic search;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bbtm_ctrl.sv =====
// Request sequencer for the block buffer tag manager.
// Depends on bbtm_pkg; drives bbtm_datapath through ctrl_cmd_t.
module bbtm_ctrl
  import bbtm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          in_ready_o   = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_SEARCH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bbtm_datapath.sv =====
// Slot tables, tag match, free-slot search, age max tree and result register.
// Depends on bbtm_pkg; sequenced by bbtm_ctrl.
module bbtm_datapath
  import bbtm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  input  logic [OP_W-1:0]       req_op_i,
  input  logic [BLK_W-1:0]      req_blk_i,
  input  logic                  cfg_we_i,
  input  logic [BLK_W-1:0]      cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [OUT_SLOT_W-1:0] out_slot_o,
  output logic                  out_wb_valid_o,
  output logic [OUT_WB_W-1:0]   out_wb_block_o
);

  logic [BLK_W-1:0]    disk_count_q;
  logic [OP_W-1:0]     req_op_q;
  logic [BLK_W-1:0]    req_blk_q;

  logic                used_q  [SLOT_COUNT];
  logic                dirty_q [SLOT_COUNT];
  logic [AGE_BITS-1:0] age_q   [SLOT_COUNT];
  logic [TAG_W-1:0]    tag_q   [SLOT_COUNT];
  logic [AGE_BITS-1:0] aged    [SLOT_COUNT];

  logic                oob_q, hit_found_q, free_found_q;
  logic [SLOT_W-1:0]   hit_idx_q, free_idx_q;
  logic [AGE_BITS-1:0] cand_age_q [CAND_N];
  logic [SLOT_W-1:0]   cand_idx_q [CAND_N];

  logic [BLK_W-1:0]    bound;
  logic                oob_d, hit_found_d, free_found_d;
  logic [SLOT_W-1:0]   hit_idx_d, free_idx_d;
  logic [AGE_BITS-1:0] t_age [TREE_N];
  logic [SLOT_W-1:0]   t_idx [TREE_N];
  logic [AGE_BITS-1:0] c_age [CAND_N];
  logic [SLOT_W-1:0]   c_idx [CAND_N];
  logic [SLOT_W-1:0]   victim_idx, pick_idx;
  logic                is_alloc, is_set_dirty;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic                out_wb_valid_q;
  logic [OUT_WB_W-1:0] out_wb_block_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign is_alloc        = (req_op_q == OP_ALLOC);
  assign is_set_dirty    = (req_op_q == OP_SET_DIRTY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_count_q <= DISK_COUNT_RESET;
    end else if (cfg_we_i) begin
      disk_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q  <= req_op_i;
      req_blk_q <= req_blk_i;
    end
  end

  // search stage: bound check, tag match, first free slot, upper levels of age tree
  always_comb begin
    bound = disk_count_q;
    if (32'(disk_count_q) > MAX_DISK_BLOCKS) begin
      bound = BLK_W'(MAX_DISK_BLOCKS);
    end
    oob_d = (req_blk_q >= bound);

    hit_found_d  = 1'b0;
    hit_idx_d    = '0;
    free_found_d = 1'b0;
    free_idx_d   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (used_q[i] && (tag_q[i] == req_blk_q[TAG_W-1:0])) begin
        hit_found_d = 1'b1;
        hit_idx_d   = SLOT_W'(i);
      end
      if (!used_q[i]) begin
        free_found_d = 1'b1;
        free_idx_d   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      aged[i] = (age_q[i] == '1) ? age_q[i] : age_q[i] + AGE_BITS'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      t_age[i] = '0;
      t_idx[i] = SLOT_W'(i);
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      t_age[i] = aged[i];
    end
    for (int lv = 0; lv < TREE_L1; lv++) begin
      for (int j = 0; j < (TREE_N >> (lv + 1)); j++) begin
        if (t_age[2*j+1] > t_age[2*j]) begin
          t_age[j] = t_age[2*j+1];
          t_idx[j] = t_idx[2*j+1];
        end else begin
          t_age[j] = t_age[2*j];
          t_idx[j] = t_idx[2*j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      oob_q        <= oob_d;
      hit_found_q  <= hit_found_d;
      hit_idx_q    <= hit_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      for (int j = 0; j < CAND_N; j++) begin
        cand_age_q[j] <= t_age[j];
        cand_idx_q[j] <= t_idx[j];
      end
    end
  end

  // decide stage: lower levels of age tree, slot choice
  always_comb begin
    for (int j = 0; j < CAND_N; j++) begin
      c_age[j] = cand_age_q[j];
      c_idx[j] = cand_idx_q[j];
    end
    for (int lv = 0; lv < TREE_L2; lv++) begin
      for (int j = 0; j < (CAND_N >> (lv + 1)); j++) begin
        if (c_age[2*j+1] > c_age[2*j]) begin
          c_age[j] = c_age[2*j+1];
          c_idx[j] = c_idx[2*j+1];
        end else begin
          c_age[j] = c_age[2*j];
          c_idx[j] = c_idx[2*j];
        end
      end
    end
    victim_idx = c_idx[0];
    pick_idx   = free_found_q ? free_idx_q : victim_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        used_q[i]  <= 1'b0;
        dirty_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else if (cmd_i.commit && !oob_q) begin
      if (is_alloc) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          age_q[i] <= aged[i];
        end
        age_q[pick_idx]   <= '0;
        used_q[pick_idx]  <= 1'b1;
        dirty_q[pick_idx] <= 1'b0;
      end else if (is_set_dirty && hit_found_q) begin
        dirty_q[hit_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !oob_q && is_alloc) begin
      tag_q[pick_idx] <= req_blk_q[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q   <= STAT_OK;
      out_slot_q     <= '0;
      out_wb_valid_q <= 1'b0;
      out_wb_block_q <= '0;
      if (oob_q) begin
        out_status_q <= STAT_OOB;
      end else if (is_alloc) begin
        out_slot_q <= OUT_SLOT_W'(pick_idx);
        if (!free_found_q && dirty_q[victim_idx]) begin
          out_wb_valid_q <= 1'b1;
          out_wb_block_q <= OUT_WB_W'(tag_q[victim_idx]);
        end
      end else if (hit_found_q) begin
        out_slot_q <= OUT_SLOT_W'(hit_idx_q);
      end else begin
        out_status_q <= STAT_MISS;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_slot_o     = out_slot_q;
  assign out_wb_valid_o = out_wb_valid_q;
  assign out_wb_block_o = out_wb_block_q;

endmodule

// ===== hw/rtl/block_buffer_tag_manager.sv =====
// Top level of the block buffer tag manager: stream ports and configuration write.
// Depends on bbtm_pkg, bbtm_ctrl and bbtm_datapath.

// Tag manager for a buffer of 32 disk-block slots; it evicts the slot least
// recently allocated. Each request item (allocate, lookup, set-dirty) yields
// exactly one result item. A request passes the search stage (bound check,
// parallel tag compare, first-free-slot encode, upper levels of the age max
// tree) and then the decide stage (lower levels of the tree, table update,
// result load). The next item is taken while the last one is in the decide
// stage, before it is through. The block stalls in the decide stage only
// while the result register is full and not taken.
// disk_block_count may be written only while no request is in flight.
module block_buffer_tag_manager
  import bbtm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [BLK_W-1:0]      cfg_wdata_i,    // disk_block_count
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // operation[1:0], block_num[15:2]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[1:0], slot_index[6:2],
                                                // writeback_valid[7],
                                                // writeback_block[20:8], zero[23:21]
);

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic [STATUS_W-1:0]   status;
  logic [OUT_SLOT_W-1:0] slot_index;
  logic                  writeback_valid;
  logic [OUT_WB_W-1:0]   writeback_block;

  bbtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbtm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_op_i       (s_axis_tdata[OP_W-1:0]),
    .req_blk_i      (s_axis_tdata[OP_W+BLK_W-1:OP_W]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (status),
    .out_slot_o     (slot_index),
    .out_wb_valid_o (writeback_valid),
    .out_wb_block_o (writeback_block)
  );

  assign m_axis_tdata = {3'b000, writeback_block, writeback_valid, slot_index, status};

endmodule
